>>> rtl/gasa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gasa_pkg
// Shared types and constants for the generational arena slot allocator.
// ============================================================================
package gasa_pkg;

    localparam int RING_LEN_DEF    = 32;
    localparam int ARENA_BYTES_DEF = 1048576;

    localparam int HANDLE_W = 32;
    localparam int BYTES_W  = 32;
    localparam int OFFSET_W = 25;
    localparam int STATUS_W = 3;
    localparam int ACTION_W = 2;

    // allocation granule minus one
    localparam logic [BYTES_W-1:0] SIZE_ROUND = 32'd15;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_EXISTS  = 2'd2,
        ACT_ALLOC   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SLOT  = 3'd1,
        ST_NOT_LIVE = 3'd2,
        ST_BAD_SIZE = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

endpackage : gasa_pkg
`default_nettype wire

>>> rtl/gasa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gasa_req_if
// Request channel: action, handle and byte count with valid/ready.
// ============================================================================
interface gasa_req_if;
    import gasa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] handle_in;
    logic [BYTES_W-1:0]  request_bytes;

    modport source (output valid, action, handle_in, request_bytes, input ready);
    modport sink   (input valid, action, handle_in, request_bytes, output ready);
endinterface : gasa_req_if
`default_nettype wire

>>> rtl/gasa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gasa_rsp_if
// Response channel: status, acquired handle and allocation offset.
// ============================================================================
interface gasa_rsp_if;
    import gasa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [OFFSET_W-1:0] offset;

    modport source (output valid, status, handle_out, offset, input ready);
    modport sink   (input valid, status, handle_out, offset, output ready);
endinterface : gasa_rsp_if
`default_nettype wire

>>> rtl/generational_arena_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// generational_arena_slot_allocator
// Ring of arena slots with generation-checked handles and a bump allocator.
// ============================================================================
// Usage:
//   i_req carries one command per transaction: acquire, release, exists or
//   allocate. o_rsp returns exactly one result per command (status, handle,
//   offset). One command is in flight at a time; i_req.ready is high only
//   while the block is idle.
//   Acquire walks the slot table from the sequence counter, one slot read
//   per cycle. Release, exists and allocate first reduce the handle modulo
//   RING_LEN one byte per cycle, then read and update the slot; a
//   successful allocate adds a step (S_OFS) for the offset multiply.
//   After the result is taken the block returns to idle, and only then
//   accepts the next command.
//   Reset (synchronous, active low) sets the sequence counter to RING_LEN and
//   marks every slot untouched, so it reads as generation RING_LEN + index
//   with an empty head; no clearing pass is needed.
//   A stalled o_rsp holds its result; the block takes no new command until
//   the result transaction completes.
// ============================================================================
module generational_arena_slot_allocator #(
    parameter int RING_LEN    = gasa_pkg::RING_LEN_DEF,
    parameter int ARENA_BYTES = gasa_pkg::ARENA_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gasa_req_if.sink    i_req,
    gasa_rsp_if.source  o_rsp
);
    import gasa_pkg::*;

    localparam int SLOT_W     = $clog2(RING_LEN);
    localparam int HEAD_W     = $clog2(ARENA_BYTES + 1);
    localparam int CNT_W      = $clog2(RING_LEN + 1);
    localparam int PROD_W     = SLOT_W + HEAD_W;
    localparam int OFF_CALC_W = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MOD  = 7'b0000010,
        S_RD   = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_OFS  = 7'b0010000,
        S_SCAN = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    t_action             r_action, n_action;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [BYTES_W-1:0]  r_size, n_size;
    logic                r_bad, n_bad;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [HEAD_W-1:0]   r_head_old, n_head_old;
    logic [HANDLE_W-1:0] r_next_seq, n_next_seq;
    logic [SLOT_W-1:0]   r_next_slot, n_next_slot;
    logic [HANDLE_W-1:0] r_scan_seq, n_scan_seq;
    logic [SLOT_W-1:0]   r_scan_slot, n_scan_slot;
    logic [CNT_W-1:0]    r_iss_cnt, n_iss_cnt;
    logic                r_cmp_vld, n_cmp_vld;
    logic [HANDLE_W-1:0] r_cmp_seq, n_cmp_seq;
    logic [SLOT_W-1:0]   r_cmp_slot, n_cmp_slot;
    logic                r_cmp_last, n_cmp_last;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_hout, n_hout;
    logic [OFFSET_W-1:0] r_off, n_off;

    logic                w_mod_start;
    logic                w_mod_done;
    logic [SLOT_W-1:0]   w_mod_rem;
    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr;
    logic [HANDLE_W-1:0] w_wgen;
    logic [HEAD_W-1:0]   w_whead;
    logic [SLOT_W-1:0]   w_raddr;
    logic [HANDLE_W-1:0] w_rgen;
    logic [HEAD_W-1:0]   w_rhead;
    logic                w_live;
    logic                w_issue;
    logic [HEAD_W:0]     w_sum;
    logic [OFF_CALC_W-1:0] w_off_full;

    // slot index of seq + 1, given slot == seq mod RING_LEN (32-bit wrap aware)
    function automatic logic [SLOT_W-1:0] f_slot_inc(input logic [SLOT_W-1:0] slot,
                                                      input logic [HANDLE_W-1:0] seq);
        logic [SLOT_W-1:0] res;
        if (seq == '1 || slot == SLOT_W'(RING_LEN - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    gasa_mod_unit #(
        .RING_LEN (RING_LEN),
        .SLOT_W   (SLOT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_req.handle_in),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    gasa_slot_ram #(
        .RING_LEN (RING_LEN),
        .SLOT_W   (SLOT_W),
        .HEAD_W   (HEAD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wgen  (w_wgen),
        .i_whead (w_whead),
        .i_raddr (w_raddr),
        .o_rgen  (w_rgen),
        .o_rhead (w_rhead)
    );

    assign w_raddr    = (r_state == S_SCAN) ? r_scan_slot : r_slot;
    assign w_live     = (w_rgen == r_handle + HANDLE_W'(1));
    assign w_sum      = {1'b0, w_rhead} + (HEAD_W + 1)'(r_size[HEAD_W-1:0]);
    assign w_issue    = (r_iss_cnt != CNT_W'(RING_LEN));
    assign w_off_full = OFF_CALC_W'(r_slot) * OFF_CALC_W'(ARENA_BYTES)
                      + OFF_CALC_W'(r_head_old);

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_handle    = r_handle;
        n_size      = r_size;
        n_bad       = r_bad;
        n_slot      = r_slot;
        n_head_old  = r_head_old;
        n_next_seq  = r_next_seq;
        n_next_slot = r_next_slot;
        n_scan_seq  = r_scan_seq;
        n_scan_slot = r_scan_slot;
        n_iss_cnt   = r_iss_cnt;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_seq   = r_cmp_seq;
        n_cmp_slot  = r_cmp_slot;
        n_cmp_last  = r_cmp_last;
        n_status    = r_status;
        n_hout      = r_hout;
        n_off       = r_off;
        w_mod_start = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wgen      = w_rgen;
        w_whead     = w_rhead;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = t_action'(i_req.action);
                    n_handle = i_req.handle_in;
                    n_size   = (i_req.request_bytes + SIZE_ROUND) & ~SIZE_ROUND;
                    n_hout   = '0;
                    n_off    = '0;
                    if (t_action'(i_req.action) == ACT_ACQUIRE) begin
                        n_scan_seq  = r_next_seq;
                        n_scan_slot = r_next_slot;
                        n_iss_cnt   = '0;
                        n_cmp_vld   = 1'b0;
                        n_state     = S_SCAN;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_bad = (r_size == '0) || (r_size >= BYTES_W'(ARENA_BYTES));
                if (w_mod_done) begin
                    n_slot  = w_mod_rem;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state  = S_DONE;
                n_status = ST_OK;
                unique case (r_action)
                    ACT_RELEASE: begin
                        if (w_live) begin
                            w_we   = 1'b1;
                            w_wgen = r_handle + HANDLE_W'(RING_LEN);
                        end else begin
                            n_status = ST_NOT_LIVE;
                        end
                    end
                    ACT_ALLOC: begin
                        if (!w_live) begin
                            n_status = ST_NOT_LIVE;
                        end else if (r_bad) begin
                            n_status = ST_BAD_SIZE;
                        end else if (w_sum > (HEAD_W + 1)'(ARENA_BYTES)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we       = 1'b1;
                            w_whead    = w_sum[HEAD_W-1:0];
                            n_head_old = w_rhead;
                            n_state    = S_OFS;
                        end
                    end
                    default: begin
                        // exists query; acquire never reaches this state
                        if (!w_live) begin
                            n_status = ST_NOT_LIVE;
                        end
                    end
                endcase
            end
            S_OFS: begin
                n_off   = w_off_full[OFFSET_W-1:0];
                n_state = S_DONE;
            end
            S_SCAN: begin
                // read pipeline: one slot issued per cycle, compared in the following cycle
                n_cmp_vld  = w_issue;
                n_cmp_seq  = r_scan_seq;
                n_cmp_slot = r_scan_slot;
                n_cmp_last = (r_iss_cnt == CNT_W'(RING_LEN - 1));
                if (w_issue) begin
                    n_scan_seq  = r_scan_seq + HANDLE_W'(1);
                    n_scan_slot = f_slot_inc(r_scan_slot, r_scan_seq);
                    n_iss_cnt   = r_iss_cnt + 1'b1;
                end
                if (r_cmp_vld) begin
                    if (w_rgen == r_cmp_seq) begin
                        w_we        = 1'b1;
                        w_waddr     = r_cmp_slot;
                        w_wgen      = r_cmp_seq + HANDLE_W'(1);
                        w_whead     = '0;
                        n_next_seq  = r_next_seq + HANDLE_W'(1);
                        n_next_slot = f_slot_inc(r_next_slot, r_next_seq);
                        n_hout      = r_cmp_seq;
                        n_status    = ST_OK;
                        n_cmp_vld   = 1'b0;
                        n_state     = S_DONE;
                    end else if (r_cmp_last) begin
                        n_status  = ST_NO_SLOT;
                        n_cmp_vld = 1'b0;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_seq  <= HANDLE_W'(RING_LEN);
            r_next_slot <= '0;
            r_cmp_vld   <= 1'b0;
            r_iss_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_next_seq  <= n_next_seq;
            r_next_slot <= n_next_slot;
            r_cmp_vld   <= n_cmp_vld;
            r_iss_cnt   <= n_iss_cnt;
        end
        r_action    <= n_action;
        r_handle    <= n_handle;
        r_size      <= n_size;
        r_bad       <= n_bad;
        r_slot      <= n_slot;
        r_head_old  <= n_head_old;
        r_scan_seq  <= n_scan_seq;
        r_scan_slot <= n_scan_slot;
        r_cmp_seq   <= n_cmp_seq;
        r_cmp_slot  <= n_cmp_slot;
        r_cmp_last  <= n_cmp_last;
        r_status    <= n_status;
        r_hout      <= n_hout;
        r_off       <= n_off;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = (r_state == S_DONE);
    assign o_rsp.status     = r_status;
    assign o_rsp.handle_out = r_hout;
    assign o_rsp.offset     = r_off;

    // a pending result and a new command never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request accepted while a result is pending");

    // handle and offset only accompany a successful result
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.handle_out == '0 && o_rsp.offset == '0))
        else $error("nonzero payload on failed result");

    // the acquire scan never issues more reads than there are slots
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_cnt <= CNT_W'(RING_LEN))
        else $error("slot scan overran the ring");

    // the sequence counter only moves by one, on a successful acquire
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_seq != $past(r_next_seq)) |->
            (o_rsp.valid && o_rsp.status == ST_OK
             && r_next_seq == $past(r_next_seq) + HANDLE_W'(1)))
        else $error("sequence counter moved without an acquire");
endmodule : generational_arena_slot_allocator
`default_nettype wire

>>> rtl/gasa_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gasa_mod_unit
// Remainder of a 32-bit handle by the ring length, one byte per cycle:
// constant tables reduce the shifted remainder and the byte, then one
// compare/subtract folds the sum.
// ============================================================================
module gasa_mod_unit #(
    parameter int RING_LEN = gasa_pkg::RING_LEN_DEF,
    parameter int SLOT_W   = $clog2(RING_LEN)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [gasa_pkg::HANDLE_W-1:0] i_dividend,
    output logic                               o_done,
    output logic [SLOT_W-1:0]                  o_rem
);
    import gasa_pkg::*;

    localparam int DIGIT_W = 8;
    localparam int DIGIT_N = 2 ** DIGIT_W;
    localparam int NSTEP   = HANDLE_W / DIGIT_W;
    localparam int CNT_W   = $clog2(NSTEP + 1);
    localparam int TAB_N   = 2 ** SLOT_W;
    localparam logic [SLOT_W:0] DIVISOR = (SLOT_W + 1)'(RING_LEN);

    logic [HANDLE_W-1:0] r_dvd, n_dvd;
    logic [SLOT_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_done, n_done;
    logic [SLOT_W:0]     w_step_sum;

    // byte mod RING_LEN, and (remainder * 256) mod RING_LEN
    logic [SLOT_W-1:0]   w_byte_rem  [DIGIT_N];
    logic [SLOT_W-1:0]   w_shift_rem [TAB_N];

    genvar gb;
    genvar gs;
    for (gb = 0; gb < DIGIT_N; gb++) begin : g_byte_rem
        assign w_byte_rem[gb] = SLOT_W'(gb % RING_LEN);
    end
    for (gs = 0; gs < TAB_N; gs++) begin : g_shift_rem
        assign w_shift_rem[gs] = SLOT_W'((gs * DIGIT_N) % RING_LEN);
    end

    // both terms are below RING_LEN, so one subtract brings the sum in range
    assign w_step_sum = {1'b0, w_shift_rem[r_rem]}
                      + {1'b0, w_byte_rem[r_dvd[HANDLE_W-1 -: DIGIT_W]]};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd = i_dividend;
            n_rem = '0;
            n_cnt = CNT_W'(NSTEP);
        end else if (r_cnt != '0) begin
            n_rem  = (w_step_sum >= DIVISOR) ? SLOT_W'(w_step_sum - DIVISOR)
                                             : w_step_sum[SLOT_W-1:0];
            n_dvd  = {r_dvd[HANDLE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule : gasa_mod_unit
`default_nettype wire

>>> rtl/gasa_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gasa_slot_ram
// Slot table: generation and bump head per slot, one write and one
// registered read per cycle. Unwritten slots read as their reset value.
// ============================================================================
module gasa_slot_ram #(
    parameter int RING_LEN = gasa_pkg::RING_LEN_DEF,
    parameter int SLOT_W   = $clog2(RING_LEN),
    parameter int HEAD_W   = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [SLOT_W-1:0]             i_waddr,
    input  wire logic [gasa_pkg::HANDLE_W-1:0] i_wgen,
    input  wire logic [HEAD_W-1:0]             i_whead,
    input  wire logic [SLOT_W-1:0]             i_raddr,
    output logic [gasa_pkg::HANDLE_W-1:0]      o_rgen,
    output logic [HEAD_W-1:0]                  o_rhead
);
    import gasa_pkg::*;

    localparam int ENTRY_W = HANDLE_W + HEAD_W;

    logic [ENTRY_W-1:0]  r_mem [RING_LEN];
    logic [RING_LEN-1:0] r_vld;
    logic [ENTRY_W-1:0]  r_rd_data;
    logic                r_rd_vld;
    logic [SLOT_W-1:0]   r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wgen, i_whead};
        end
        r_rd_data <= r_mem[i_raddr];
        r_rd_addr <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    // untouched slot: generation = ring length + index, head = 0
    assign o_rgen  = r_rd_vld ? r_rd_data[ENTRY_W-1:HEAD_W]
                              : HANDLE_W'(RING_LEN) + HANDLE_W'(r_rd_addr);
    assign o_rhead = r_rd_vld ? r_rd_data[HEAD_W-1:0] : '0;
endmodule : gasa_slot_ram
`default_nettype wire
